>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of this project.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/nnr_pkg.sv
// Package of the nearest-neighbor ratio test block: default widths,
// register reset values and configuration register codes. No dependencies.
package nnr_pkg;

    // Default field widths.
    localparam int CAND_BITS_DEF = 12;
    localparam int DIST_BITS_DEF = 12;
    localparam int ROW_BITS_DEF  = 16;

    // Ratio threshold register: Q1.8 with one integer bit.
    localparam int RATIO_BITS = 9;
    localparam int FRAC_BITS  = 8;
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 9'd205;

    // Configuration register codes.
    typedef enum logic [0:0] {
        REG_RATIO = 1'b0,
        REG_LIMIT = 1'b1
    } cfg_reg_t;

endpackage

>>> hw/rtl/nnr_cand_if.sv
// Candidate entry channel: valid/ready handshake plus one candidate word.
// Depends on nnr_pkg for the default widths.
interface nnr_cand_if #(
    parameter int CAND_BITS = nnr_pkg::CAND_BITS_DEF,
    parameter int DIST_BITS = nnr_pkg::DIST_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [CAND_BITS-1:0] candidate_index;
    logic [DIST_BITS-1:0] distance;
    logic                 excluded;
    logic                 row_end;

    modport source (output valid, candidate_index, distance, excluded, row_end,
                    input ready);
    modport sink   (input valid, candidate_index, distance, excluded, row_end,
                    output ready);
endinterface

>>> hw/rtl/nnr_result_if.sv
// Result channel: valid/ready handshake plus one match result word.
// Depends on nnr_pkg for the default widths.
interface nnr_result_if #(
    parameter int ROW_BITS  = nnr_pkg::ROW_BITS_DEF,
    parameter int CAND_BITS = nnr_pkg::CAND_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [ROW_BITS-1:0]  query_number;
    logic [CAND_BITS-1:0] best_index;
    logic                 matched;

    modport source (output valid, query_number, best_index, matched, input ready);
    modport sink   (input valid, query_number, best_index, matched, output ready);
endinterface

>>> hw/rtl/nearest_neighbor_ratio_test_top.sv
// Nearest-neighbor ratio test: tracks best and second-best distance per query row.
// Depends on nnr_pkg, nnr_cand_if and nnr_result_if.
// Throughput: one candidate word per cycle while the result side keeps up.
// Path: the edge that accepts a row's last word captures its final state in the capture
// stage; the multiply/compare then loads the result register once that register is free.
// Reset: config registers to defaults, row state and query number to zero, stages empty.
module nearest_neighbor_ratio_test_top #(
    parameter int CAND_BITS = nnr_pkg::CAND_BITS_DEF,
    parameter int DIST_BITS = nnr_pkg::DIST_BITS_DEF,
    parameter int ROW_BITS  = nnr_pkg::ROW_BITS_DEF,
    localparam int CFG_BITS = (DIST_BITS > nnr_pkg::RATIO_BITS) ?
                              DIST_BITS : nnr_pkg::RATIO_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    nnr_cand_if.sink            cand,
    nnr_result_if.source        result,
    input  logic                cfg_write,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    localparam int RATIO_BITS = nnr_pkg::RATIO_BITS;
    localparam int PROD_BITS  = DIST_BITS + RATIO_BITS;

    // Configuration registers.
    logic [RATIO_BITS-1:0] ratio_reg;
    logic [DIST_BITS-1:0]  limit_reg;

    // Running row state.
    logic [DIST_BITS-1:0] best_dist_reg;
    logic                 best_valid_reg;
    logic [DIST_BITS-1:0] second_dist_reg;
    logic                 second_valid_reg;
    logic [CAND_BITS-1:0] best_cand_reg;
    logic [ROW_BITS-1:0]  row_count_reg;

    // Captured row, waiting for the ratio test.
    logic                 fin_valid_reg;
    logic [DIST_BITS-1:0] fin_best_dist_reg;
    logic                 fin_best_valid_reg;
    logic [DIST_BITS-1:0] fin_second_dist_reg;
    logic                 fin_second_valid_reg;
    logic [CAND_BITS-1:0] fin_cand_reg;
    logic [ROW_BITS-1:0]  fin_row_reg;

    // Result register.
    logic                 out_valid_reg;
    logic [ROW_BITS-1:0]  out_row_reg;
    logic [CAND_BITS-1:0] out_cand_reg;
    logic                 out_match_reg;

    logic                 out_load_ok;
    logic                 fin_move;
    logic                 fin_free;
    logic                 in_fire;
    logic                 take_best;
    logic                 take_second;
    logic [DIST_BITS-1:0] best_dist_next;
    logic                 best_valid_next;
    logic [DIST_BITS-1:0] second_dist_next;
    logic                 second_valid_next;
    logic [CAND_BITS-1:0] best_cand_next;
    logic                 within_limit;
    logic [PROD_BITS-1:0] ratio_prod;
    logic [PROD_BITS-1:0] best_scaled;
    logic                 ratio_ok;
    logic                 match_next;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= nnr_pkg::RATIO_RESET;
            limit_reg <= '1;
        end
        else if (cfg_write)
        begin
            unique case (nnr_pkg::cfg_reg_t'(cfg_index))
                nnr_pkg::REG_RATIO: ratio_reg <= cfg_data[RATIO_BITS-1:0];
                nnr_pkg::REG_LIMIT: limit_reg <= cfg_data[DIST_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the capture stage frees up when the result register can load.
    assign out_load_ok = !out_valid_reg || result.ready;
    assign fin_move    = fin_valid_reg && out_load_ok;
    assign fin_free    = !fin_valid_reg || out_load_ok;
    assign cand.ready  = fin_free;
    assign in_fire     = cand.valid && fin_free;

    // Best and second-best update; ties never replace.
    always_comb
    begin
        take_best   = !cand.excluded &&
                      (!best_valid_reg || (cand.distance < best_dist_reg));
        take_second = !cand.excluded && !take_best &&
                      (!second_valid_reg || (cand.distance < second_dist_reg));

        best_dist_next    = best_dist_reg;
        best_valid_next   = best_valid_reg;
        best_cand_next    = best_cand_reg;
        second_dist_next  = second_dist_reg;
        second_valid_next = second_valid_reg;
        if (take_best)
        begin
            second_dist_next  = best_dist_reg;
            second_valid_next = best_valid_reg;
            best_dist_next    = cand.distance;
            best_valid_next   = 1'b1;
            best_cand_next    = cand.candidate_index;
        end
        else if (take_second)
        begin
            second_dist_next  = cand.distance;
            second_valid_next = 1'b1;
        end
    end

    // Row state: cleared after the last word of a row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg   <= 1'b0;
            second_valid_reg <= 1'b0;
            row_count_reg    <= '0;
        end
        else if (in_fire)
        begin
            if (cand.row_end)
            begin
                best_valid_reg   <= 1'b0;
                second_valid_reg <= 1'b0;
                row_count_reg    <= row_count_reg + ROW_BITS'(1);
            end
            else
            begin
                best_valid_reg   <= best_valid_next;
                second_valid_reg <= second_valid_next;
            end
        end
    end

    // Distance and index payload; only read while the matching valid bit is set.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            best_dist_reg   <= best_dist_next;
            second_dist_reg <= second_dist_next;
            best_cand_reg   <= best_cand_next;
        end
    end

    // Capture stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (in_fire && cand.row_end)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (fin_move)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    // Capture stage payload: the row's final state including its last word.
    always_ff @(posedge clk)
    begin
        if (in_fire && cand.row_end)
        begin
            fin_best_dist_reg    <= best_dist_next;
            fin_best_valid_reg   <= best_valid_next;
            fin_second_dist_reg  <= second_dist_next;
            fin_second_valid_reg <= second_valid_next;
            fin_cand_reg         <= best_cand_next;
            fin_row_reg          <= row_count_reg;
        end
    end

    // Distance limit and exact ratio test: best * 256 < ratio * second.
    always_comb
    begin
        within_limit = fin_best_valid_reg && (fin_best_dist_reg <= limit_reg);
        ratio_prod   = PROD_BITS'(ratio_reg) * PROD_BITS'(fin_second_dist_reg);
        best_scaled  = PROD_BITS'(fin_best_dist_reg) << nnr_pkg::FRAC_BITS;
        ratio_ok     = !fin_second_valid_reg || (best_scaled < ratio_prod);
        match_next   = within_limit && ratio_ok;
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (fin_move)
        begin
            out_row_reg   <= fin_row_reg;
            out_cand_reg  <= fin_best_valid_reg ? fin_cand_reg : '0;
            out_match_reg <= match_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.query_number = out_row_reg;
    assign result.best_index   = out_cand_reg;
    assign result.matched      = out_match_reg;

endmodule

>>> hw/rtl/nnr_checker.sv
// Port-level checker for the nearest-neighbor ratio test, bound to the top level.
// Depends on assert_macros.svh and nearest_neighbor_ratio_test_top.
`include "assert_macros.svh"

module nnr_checker #(
    parameter int CAND_BITS = nnr_pkg::CAND_BITS_DEF,
    parameter int ROW_BITS  = nnr_pkg::ROW_BITS_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cand_valid,
    input logic                 cand_ready,
    input logic                 row_end,
    input logic                 res_valid,
    input logic                 res_ready,
    input logic [ROW_BITS-1:0]  query_number,
    input logic [CAND_BITS-1:0] best_index,
    input logic                 matched
);

    logic                          row_fire;
    logic                          res_fire;
    logic [1:0]                    pend_reg;
    logic [1:0]                    pend_next;
    logic                          seen_reg;
    logic [ROW_BITS-1:0]           last_reg;
    logic [ROW_BITS-1:0]           next_query;
    logic [ROW_BITS+CAND_BITS:0]   res_word;

    assign row_fire   = cand_valid && cand_ready && row_end;
    assign res_fire   = res_valid && res_ready;
    assign next_query = last_reg + ROW_BITS'(1);
    assign res_word   = {query_number, best_index, matched};

    // Rows accepted whose result has not yet been delivered.
    always_comb
    begin
        pend_next = pend_reg;
        if (row_fire && !res_fire)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!row_fire && res_fire)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    // Tracking of pending rows and the last delivered query number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            seen_reg <= 1'b0;
            last_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (res_fire)
            begin
                seen_reg <= 1'b1;
                last_reg <= query_number;
            end
        end
    end

    // A stalled result word stays valid and unchanged.
    `ASSERT_NEXT(a_valid_holds, clk, rst_n, res_valid && !res_ready, res_valid)
    `ASSERT_NEXT(a_word_holds, clk, rst_n, res_valid && !res_ready, $stable(res_word))

    // No result without a finished row behind it.
    `ASSERT_IMPLIES(a_no_invented, clk, rst_n, res_valid, pend_reg != 2'd0)

    // Query numbers come out in order, one per row.
    `ASSERT_IMPLIES(a_in_order, clk, rst_n, res_fire && seen_reg, query_number == next_query)

endmodule

bind nearest_neighbor_ratio_test_top nnr_checker #(
    .CAND_BITS (CAND_BITS),
    .ROW_BITS  (ROW_BITS)
) u_nnr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cand_valid   (cand.valid),
    .cand_ready   (cand.ready),
    .row_end      (cand.row_end),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .query_number (result.query_number),
    .best_index   (result.best_index),
    .matched      (result.matched)
);
